FILE: rtl/ptcc_pkg.sv
// ----------------------------------------------------------------------------
// ptcc_pkg
// Types and constants shared by the periodic task conflict checker.
// ----------------------------------------------------------------------------
package ptcc_pkg;

    localparam int TIME_W = 31;
    localparam int ST_W   = TIME_W + 2;

    typedef struct packed {
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] end_time;
        logic [TIME_W-1:0] period;
        logic              last;
    } ptcc_in_t;

    typedef struct packed {
        logic conflict;
        logic overflow;
    } ptcc_out_t;

    typedef struct packed {
        logic [ST_W-1:0]   start;
        logic [ST_W-1:0]   fin;
        logic [TIME_W-1:0] period;
    } ptcc_entry_t;

    typedef struct packed {
        logic push;
        logic scan_clr;
        logic scan_rd;
        logic reinsert;
        logic take_last;
        logic move_wr;
        logic emit;
        logic emit_conflict;
    } ptcc_cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic scan_last;
        logic below_hz;
        logic hit_busy;
        logic periodic;
        logic out_free;
    } ptcc_sts_t;

endpackage

FILE: rtl/periodic_task_conflict_check.sv
// ----------------------------------------------------------------------------
// periodic_task_conflict_check
// Collects a set of periodic tasks and checks their occurrences for overlap.
//
// Input channel s_*: one beat per task, s_data.last marks the final task.
// A task beat without last is taken and s_ready is high again in
// the next cycle. A beat with last starts the sweep; s_ready stays low until
// the result has been loaded into the output register.
// Each sweep step scans the stored tasks through the single read port of the
// task memory, one entry per cycle; removing a one-off task adds a move step
// (the last stored entry is copied into its slot). The number of steps
// depends on the data and the horizon.
// Result channel m_*: one beat per task set with conflict and overflow. The
// result is held in an output register until m_ready; while it waits, new
// task beats are still taken.
// cfg_we/cfg_wdata write the horizon; write it only while the block is idle.
// Reset clears the horizon, the task count, busy-until and the overflow
// flag; the task memory needs no clearing.
// ----------------------------------------------------------------------------
module periodic_task_conflict_check import ptcc_pkg::*; #(
    parameter int MAX_TASKS = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [TIME_W-1:0] cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  ptcc_in_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ptcc_out_t         m_data
);

    ptcc_cmd_t cmd;
    ptcc_sts_t sts;

    ptcc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_data.last),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ptcc_dp #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

FILE: rtl/ptcc_dp.sv
// ----------------------------------------------------------------------------
// ptcc_dp
// Task store, minimum scan, busy-until tracking and result register.
// ----------------------------------------------------------------------------
module ptcc_dp import ptcc_pkg::*; #(
    parameter int MAX_TASKS = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [TIME_W-1:0] cfg_wdata,
    input  ptcc_in_t          in_data,
    input  ptcc_cmd_t         cmd,
    output ptcc_sts_t         sts,
    output logic              m_valid,
    input  logic              m_ready,
    output ptcc_out_t         m_data
);

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    ptcc_entry_t mem [MAX_TASKS];

    logic [TIME_W-1:0] hz_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ST_W-1:0]   busy_reg, busy_next;
    logic              ovf_reg, ovf_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic              rdv_reg;
    ptcc_entry_t       rd_data_reg;
    ptcc_entry_t       best_reg, best_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic              best_v_reg, best_v_next;
    logic              m_valid_reg, m_valid_next;
    ptcc_out_t         m_data_reg;

    logic              full;
    logic [CNT_W-1:0]  cnt_m1;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    ptcc_entry_t       wr_data;

    assign full    = (cnt_reg == CNT_W'(MAX_TASKS));
    assign cnt_m1  = cnt_reg - 1'b1;
    assign rd_addr = cmd.scan_rd ? idx_reg : cnt_m1[IDX_W-1:0];

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = best_idx_reg;
        wr_data = rd_data_reg;
        if (cmd.push) begin
            wr_en   = !full;
            wr_addr = cnt_reg[IDX_W-1:0];
            wr_data.start  = ST_W'(in_data.start_time);
            wr_data.fin    = ST_W'(in_data.end_time);
            wr_data.period = in_data.period;
        end else if (cmd.reinsert) begin
            wr_en   = 1'b1;
            wr_data.start  = best_reg.start + ST_W'(best_reg.period);
            wr_data.fin    = best_reg.fin + ST_W'(best_reg.period);
            wr_data.period = best_reg.period;
        end else if (cmd.move_wr) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
        if (cmd.scan_rd) begin
            rd_idx_reg <= idx_reg;
        end
    end

    always_comb begin
        cnt_next      = cnt_reg;
        busy_next     = busy_reg;
        ovf_next      = ovf_reg;
        idx_next      = idx_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        best_v_next   = best_v_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        if (cmd.push) begin
            if (full) begin
                ovf_next = 1'b1;
            end else begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
        if (cmd.scan_clr) begin
            idx_next    = '0;
            best_v_next = 1'b0;
        end
        if (cmd.scan_rd) begin
            idx_next = idx_reg + 1'b1;
        end
        if (rdv_reg && (!best_v_reg || (rd_data_reg < best_reg))) begin
            best_next     = rd_data_reg;
            best_idx_next = rd_idx_reg;
            best_v_next   = 1'b1;
        end
        if (cmd.reinsert || cmd.take_last) begin
            busy_next = best_reg.fin;
        end
        if (cmd.move_wr) begin
            cnt_next = cnt_m1;
        end
        if (cmd.emit) begin
            m_valid_next = 1'b1;
            cnt_next     = '0;
            busy_next    = '0;
            ovf_next     = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hz_reg      <= '0;
            cnt_reg     <= '0;
            busy_reg    <= '0;
            ovf_reg     <= 1'b0;
            idx_reg     <= '0;
            rdv_reg     <= 1'b0;
            best_v_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                hz_reg <= cfg_wdata;
            end
            cnt_reg     <= cnt_next;
            busy_reg    <= busy_next;
            ovf_reg     <= ovf_next;
            idx_reg     <= idx_next;
            rdv_reg     <= cmd.scan_rd;
            best_v_reg  <= best_v_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        if (cmd.emit) begin
            m_data_reg.conflict <= cmd.emit_conflict;
            m_data_reg.overflow <= ovf_reg;
        end
    end

    assign sts.cnt_zero  = (cnt_reg == '0);
    assign sts.scan_last = (CNT_W'(idx_reg) == cnt_m1);
    assign sts.below_hz  = (best_reg.start < ST_W'(hz_reg));
    assign sts.hit_busy  = (best_reg.start < busy_reg);
    assign sts.periodic  = (best_reg.period != '0);
    assign sts.out_free  = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: rtl/ptcc_ctrl.sv
// ----------------------------------------------------------------------------
// ptcc_ctrl
// Sequencer for task loading, sweep steps and result hand-off.
// ----------------------------------------------------------------------------
module ptcc_ctrl import ptcc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_last,
    output logic      s_ready,
    input  ptcc_sts_t sts,
    output ptcc_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_START  = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_DECIDE = 3'd4;
    localparam logic [2:0] ST_MOVE   = 3'd5;
    localparam logic [2:0] ST_EMIT   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       conf_reg, conf_next;

    always_comb begin
        state_next = state_reg;
        conf_next  = conf_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.push = 1'b1;
                    if (s_last) begin
                        state_next = ST_START;
                    end
                end
            end
            ST_START: begin
                if (sts.cnt_zero) begin
                    conf_next  = 1'b0;
                    state_next = ST_EMIT;
                end else begin
                    cmd.scan_clr = 1'b1;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan_rd = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                priority if (!sts.below_hz) begin
                    conf_next  = 1'b0;
                    state_next = ST_EMIT;
                end else if (sts.hit_busy) begin
                    conf_next  = 1'b1;
                    state_next = ST_EMIT;
                end else if (sts.periodic) begin
                    cmd.reinsert = 1'b1;
                    state_next   = ST_START;
                end else begin
                    cmd.take_last = 1'b1;
                    state_next    = ST_MOVE;
                end
            end
            ST_MOVE: begin
                cmd.move_wr = 1'b1;
                state_next  = ST_START;
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit          = 1'b1;
                    cmd.emit_conflict = conf_reg;
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            conf_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            conf_reg  <= conf_next;
        end
    end

endmodule
